### hw/rtl/dtd_pkg.sv
// ---------------------------------------------------------------------------
// dtd_pkg: shared types and constants of the task dispatch core
// Sizes, command and outcome codes, and the hazard test between two tasks.
// ---------------------------------------------------------------------------
package dtd_pkg;

  localparam int QueueDepth = 16;
  localparam int NumWorkers = 8;
  localparam int MaskBits   = 32;
  localparam int QIdxW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);
  localparam int WIdW       = 3;
  localparam int TagW       = 16;

  localparam logic [1:0] CmdPush     = 2'd0;
  localparam logic [1:0] CmdRequest  = 2'd1;
  localparam logic [1:0] CmdExclReq  = 2'd2;
  localparam logic [1:0] CmdExclDone = 2'd3;

  localparam logic [2:0] OutQueued     = 3'd0;
  localparam logic [2:0] OutDispatched = 3'd1;
  localparam logic [2:0] OutNone       = 3'd2;
  localparam logic [2:0] OutFull       = 3'd3;
  localparam logic [2:0] OutGranted    = 3'd4;
  localparam logic [2:0] OutWaiting    = 3'd5;

  typedef struct packed {
    logic [MaskBits-1:0] rd;
    logic [MaskBits-1:0] wr;
    logic [MaskBits-1:0] qry;
  } masks_t;

  typedef struct packed {
    masks_t          m;
    logic [TagW-1:0] tag;
  } task_t;

  // Control from the sequencer to every queue cell.
  typedef struct packed {
    logic             load;     // write the incoming task at the tail
    logic             collapse; // remove the selected entry, shift the tail down
    logic [QIdxW-1:0] tail;
    logic [QIdxW-1:0] sel;
  } cell_ctl_t;

  function automatic logic conflicts(masks_t a, masks_t b);
    logic [MaskBits-1:0] common;
    logic nested;
    logic overlap;
    common  = a.qry & b.qry;
    nested  = (common == a.qry) || (common == b.qry);
    overlap = |((a.rd & b.wr) | (a.wr & b.rd) | (a.wr & b.wr));
    return nested && overlap;
  endfunction

endpackage

### hw/rtl/dtd_cell.sv
// ---------------------------------------------------------------------------
// dtd_cell: one queue slot
// Holds one task, reports whether it is blocked, and takes its upper
// neighbor's task when the queue collapses at its slot or below it.
// ---------------------------------------------------------------------------
module dtd_cell (
  input  logic                        clk,
  input  logic [dtd_pkg::QIdxW-1:0]   idx,
  input  dtd_pkg::cell_ctl_t          ctl,
  input  dtd_pkg::task_t              new_task,
  input  dtd_pkg::task_t              upper_task,
  input  logic [dtd_pkg::NumWorkers-1:0] busy,
  input  dtd_pkg::masks_t             busy_m [dtd_pkg::NumWorkers],
  input  dtd_pkg::masks_t             excl_m,
  output dtd_pkg::task_t              task_q,
  output logic                        blocked
);

  dtd_pkg::task_t task_r;

  always_ff @(posedge clk) begin
    if (ctl.load && ctl.tail == idx) begin
      task_r <= new_task;
    end else if (ctl.collapse && idx >= ctl.sel) begin
      task_r <= upper_task;
    end
  end

  always_comb begin
    blocked = dtd_pkg::conflicts(excl_m, task_r.m);
    for (int k = 0; k < dtd_pkg::NumWorkers; k++) begin
      if (busy[k] && dtd_pkg::conflicts(busy_m[k], task_r.m)) blocked = 1'b1;
    end
  end

  assign task_q = task_r;

endmodule

### hw/rtl/dependency_aware_task_dispatch_core.sv
// ---------------------------------------------------------------------------
// dependency_aware_task_dispatch_core: hazard-checked task dispatcher
// Queues tasks and hands each requesting worker the oldest safe one.
// ---------------------------------------------------------------------------
// Usage: one input channel (in_valid/in_ready) carries commands: push a
// task, a worker's request for work, an exclusive task request, or
// exclusive done. Every transaction yields exactly one result on the
// out_valid/out_ready channel.
// Timing: a command is taken into the command register at its accepting
// edge. Once the output register is free or being taken, every queue cell
// checks its task against all workers in parallel, the oldest clear entry
// is picked, and the result is written to the output register. Throughput
// is one transaction per cycle while out_ready stays high; the hazard check
// and pick are combinational between the command and output registers.
// While a result waits in the output register the block may take the next
// transaction; it holds off only while a command waits in the command
// register and the output register is full and not being taken.
// Reset (rst_n low, synchronous) empties the queue, idles all workers and
// clears the exclusive task. Queue contents need no reset.
// ---------------------------------------------------------------------------
module dependency_aware_task_dispatch_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [2:0]  in_worker_id,
  input  logic [15:0] in_task_tag,
  input  logic [31:0] in_read_mask,
  input  logic [31:0] in_write_mask,
  input  logic [31:0] in_query_mask,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_outcome,
  output logic [15:0] out_out_tag,
  output logic [2:0]  out_out_worker,
  output logic        out_queue_empty,
  output logic        out_all_idle
);

  localparam int NW = dtd_pkg::NumWorkers;
  localparam int QD = dtd_pkg::QueueDepth;

  // command register
  logic        pend_r, pend_nxt;
  logic [1:0]  cmd_r;
  logic [2:0]  wid_r;
  dtd_pkg::task_t in_task_r;

  logic [dtd_pkg::QCntW-1:0] count_r, count_nxt;
  logic [NW-1:0]   busy_r, busy_nxt;
  dtd_pkg::masks_t busy_m_r [NW];
  dtd_pkg::masks_t excl_m_r, excl_m_nxt;
  logic            excl_active_r, excl_active_nxt;
  logic            excl_wait_r, excl_wait_nxt;
  dtd_pkg::task_t  excl_pend_r;

  logic            ovalid_r;
  logic [2:0]      oc_r;
  logic [15:0]     otag_r;
  logic [2:0]      owk_r;
  logic            oempty_r, oidle_r;

  dtd_pkg::cell_ctl_t ctl;
  dtd_pkg::task_t cell_task [QD];
  dtd_pkg::task_t upper [QD];
  logic [QD-1:0]  cell_blk;
  dtd_pkg::task_t zero_task;

  // Busy set after retiring the requesting worker; cells test against it.
  logic [NW-1:0]  busy_chk;
  logic           do_step;
  logic           wid_ok;

  assign zero_task = '0;
  assign wid_ok    = ({1'b0, wid_r} < 4'(NW));
  assign do_step   = pend_r && (!ovalid_r || out_ready);
  assign in_ready  = !pend_r || do_step;

  always_comb begin
    busy_chk = busy_r;
    if (cmd_r == dtd_pkg::CmdRequest && wid_ok) busy_chk[wid_r] = 1'b0;
  end

  for (genvar g = 0; g < QD; g++) begin : g_cell
    if (g == QD - 1) begin : g_top
      assign upper[g] = zero_task;
    end else begin : g_mid
      assign upper[g] = cell_task[g+1];
    end
    dtd_cell u_cell (
      .clk       (clk),
      .idx       (dtd_pkg::QIdxW'(g)),
      .ctl       (ctl),
      .new_task  (in_task_r),
      .upper_task(upper[g]),
      .busy      (busy_chk),
      .busy_m    (busy_m_r),
      .excl_m    (excl_m_r),
      .task_q    (cell_task[g]),
      .blocked   (cell_blk[g])
    );
  end

  // Oldest eligible entry: priority pick over the cell row.
  logic                   found;
  logic [dtd_pkg::QIdxW-1:0] pick;
  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int i = QD - 1; i >= 0; i--) begin
      if (dtd_pkg::QCntW'(i) < count_r && !cell_blk[i]) begin
        found = 1'b1;
        pick  = dtd_pkg::QIdxW'(i);
      end
    end
  end

  // A new exclusive request is checked with its own masks, a waiting one
  // with the stored masks.
  dtd_pkg::masks_t excl_chk_m;
  assign excl_chk_m = (cmd_r == dtd_pkg::CmdExclReq) ? in_task_r.m : excl_pend_r.m;

  logic excl_blk;
  always_comb begin
    excl_blk = 1'b0;
    for (int k = 0; k < NW; k++) begin
      if (busy_chk[k] && dtd_pkg::conflicts(busy_m_r[k], excl_chk_m)) excl_blk = 1'b1;
    end
  end

  logic [2:0]  oc;
  logic [15:0] otag;
  logic [2:0]  owk;
  logic        set_busy;

  always_comb begin
    count_nxt       = count_r;
    busy_nxt        = busy_chk;
    excl_m_nxt      = excl_m_r;
    excl_active_nxt = excl_active_r;
    excl_wait_nxt   = excl_wait_r;
    oc   = dtd_pkg::OutNone;
    otag = '0;
    owk  = '0;
    set_busy = 1'b0;
    ctl = '0;
    ctl.tail = count_r[dtd_pkg::QIdxW-1:0];
    ctl.sel  = pick;
    case (cmd_r)
      dtd_pkg::CmdPush: begin
        if (count_r >= dtd_pkg::QCntW'(QD)) begin
          oc = dtd_pkg::OutFull;
        end else begin
          ctl.load  = 1'b1;
          count_nxt = count_r + 1'b1;
          oc = dtd_pkg::OutQueued;
        end
      end
      dtd_pkg::CmdRequest: begin
        if (wid_ok) begin
          if (excl_wait_r) begin
            if (!excl_blk) begin
              excl_m_nxt      = excl_pend_r.m;
              excl_active_nxt = 1'b1;
              excl_wait_nxt   = 1'b0;
              oc   = dtd_pkg::OutGranted;
              otag = excl_pend_r.tag;
            end else begin
              oc = dtd_pkg::OutWaiting;
            end
          end else if (found) begin
            set_busy = 1'b1;
            busy_nxt[wid_r] = 1'b1;
            ctl.collapse = 1'b1;
            count_nxt = count_r - 1'b1;
            oc   = dtd_pkg::OutDispatched;
            otag = cell_task[pick].tag;
            owk  = wid_r;
          end
        end
      end
      dtd_pkg::CmdExclReq: begin
        oc = dtd_pkg::OutWaiting;
        if (!excl_wait_r && !excl_active_r) begin
          if (!excl_blk) begin
            excl_m_nxt      = in_task_r.m;
            excl_active_nxt = 1'b1;
            oc   = dtd_pkg::OutGranted;
            otag = in_task_r.tag;
          end else begin
            excl_wait_nxt = 1'b1;
          end
        end
      end
      default: begin
        if (excl_active_r) begin
          excl_m_nxt      = '0;
          excl_active_nxt = 1'b0;
        end
      end
    endcase
    if (!do_step) begin
      ctl.load     = 1'b0;
      ctl.collapse = 1'b0;
    end
  end

  always_comb begin
    pend_nxt = pend_r;
    if (do_step) pend_nxt = 1'b0;
    if (in_valid && in_ready) pend_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r     <= in_cmd;
      wid_r     <= in_worker_id;
      in_task_r <= '{m: '{rd: in_read_mask, wr: in_write_mask, qry: in_query_mask},
                     tag: in_task_tag};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NW; k++) busy_m_r[k] <= '0;
    end else if (do_step) begin
      if (cmd_r == dtd_pkg::CmdRequest && wid_ok) begin
        busy_m_r[wid_r] <= set_busy ? cell_task[pick].m : '0;
      end
      if (cmd_r == dtd_pkg::CmdExclReq && !excl_wait_r && !excl_active_r) begin
        excl_pend_r <= in_task_r;
      end
      oc_r     <= oc;
      otag_r   <= otag;
      owk_r    <= owk;
      oempty_r <= (count_nxt == '0);
      oidle_r  <= (busy_nxt == '0) && !excl_wait_nxt && !excl_active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r        <= 1'b0;
      count_r       <= '0;
      busy_r        <= '0;
      excl_m_r      <= '0;
      excl_active_r <= 1'b0;
      excl_wait_r   <= 1'b0;
      ovalid_r      <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      if (do_step) begin
        count_r       <= count_nxt;
        busy_r        <= busy_nxt;
        excl_m_r      <= excl_m_nxt;
        excl_active_r <= excl_active_nxt;
        excl_wait_r   <= excl_wait_nxt;
        ovalid_r      <= 1'b1;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = ovalid_r;
  assign out_outcome     = oc_r;
  assign out_out_tag     = otag_r;
  assign out_out_worker  = owk_r;
  assign out_queue_empty = oempty_r;
  assign out_all_idle    = oidle_r;

endmodule

### verif/tb_dependency_aware_task_dispatch_core.sv
// ---------------------------------------------------------------------------
// tb_dependency_aware_task_dispatch_core: self-checking dispatcher testbench
// Drives push, request and exclusive commands through the valid/ready input
// channel. A local scheduler model predicts every result, and the checker
// compares each result transaction against the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_dependency_aware_task_dispatch_core;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  wid;
    logic [15:0] tag;
    logic [31:0] rd;
    logic [31:0] wr;
    logic [31:0] qry;
  } cmd_item_t;

  typedef struct packed {
    logic [2:0]  outcome;
    logic [15:0] tag;
    logic [2:0]  worker;
    logic        qempty;
    logic        idle;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_cmd = '0;
  logic [2:0]  in_worker_id = '0;
  logic [15:0] in_task_tag = '0;
  logic [31:0] in_read_mask = '0;
  logic [31:0] in_write_mask = '0;
  logic [31:0] in_query_mask = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_outcome;
  logic [15:0] out_out_tag;
  logic [2:0]  out_out_worker;
  logic        out_queue_empty;
  logic        out_all_idle;

  dependency_aware_task_dispatch_core dut (.*);

  // Scheduler model state.
  dtd_pkg::masks_t          q_m[dtd_pkg::QueueDepth];
  logic [dtd_pkg::TagW-1:0] q_tag[dtd_pkg::QueueDepth];
  int                       q_cnt;
  dtd_pkg::masks_t          wk_m[dtd_pkg::NumWorkers];
  logic [dtd_pkg::NumWorkers-1:0] wk_busy;
  dtd_pkg::masks_t          ex_m, ex_pend;
  logic [dtd_pkg::TagW-1:0] ex_pend_tag;
  logic                     ex_active, ex_waiting;

  cmd_item_t pending_cmds[$];
  answer_t   expected_answers[$];
  int errors = 0;
  int checked = 0;
  int cycle = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_go = 1'b0;
  bit hold_off = 1'b0;
  logic in_accepted = 1'b0;
  int n_disp = 0, n_grant = 0, n_full = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  // Long receiver hold-off, timed here once the main sequence starts it.
  initial begin
    wait (hold_go);
    hold_off = 1'b1;
    repeat (200) @(posedge clk);
    hold_off = 1'b0;
  end

  function automatic logic hazard(dtd_pkg::masks_t a, dtd_pkg::masks_t b);
    logic [31:0] c;
    c = a.qry & b.qry;
    return ((c == a.qry) || (c == b.qry)) &&
           (((a.rd & b.wr) | (a.wr & b.rd) | (a.wr & b.wr)) != 0);
  endfunction

  function automatic logic is_blocked(dtd_pkg::masks_t t);
    for (int k = 0; k < dtd_pkg::NumWorkers; k++)
      if (wk_busy[k] && hazard(wk_m[k], t)) return 1'b1;
    return hazard(ex_m, t);
  endfunction

  function automatic answer_t schedule_step(cmd_item_t c);
    answer_t a;
    dtd_pkg::masks_t m;
    int      i;
    a = '0;
    a.outcome = dtd_pkg::OutNone;
    m.rd = c.rd;
    m.wr = c.wr;
    m.qry = c.qry;
    case (c.cmd)
      dtd_pkg::CmdPush: begin
        if (q_cnt >= dtd_pkg::QueueDepth) begin
          a.outcome = dtd_pkg::OutFull;
        end else begin
          q_m[q_cnt] = m;
          q_tag[q_cnt] = c.tag;
          q_cnt++;
          a.outcome = dtd_pkg::OutQueued;
        end
      end
      dtd_pkg::CmdRequest: begin
        wk_busy[c.wid] = 1'b0;
        wk_m[c.wid] = '0;
        if (ex_waiting) begin
          if (!is_blocked(ex_pend)) begin
            ex_m = ex_pend;
            ex_active = 1'b1;
            ex_waiting = 1'b0;
            a.outcome = dtd_pkg::OutGranted;
            a.tag = ex_pend_tag;
          end else begin
            a.outcome = dtd_pkg::OutWaiting;
          end
        end else begin
          for (i = 0; i < q_cnt; i++)
            if (!is_blocked(q_m[i])) break;
          if (i < q_cnt) begin
            wk_m[c.wid] = q_m[i];
            wk_busy[c.wid] = 1'b1;
            a.tag = q_tag[i];
            a.worker = c.wid;
            a.outcome = dtd_pkg::OutDispatched;
            for (int j = i; j + 1 < q_cnt; j++) begin
              q_m[j] = q_m[j + 1];
              q_tag[j] = q_tag[j + 1];
            end
            q_cnt--;
          end
        end
      end
      dtd_pkg::CmdExclReq: begin
        if (ex_waiting || ex_active) begin
          a.outcome = dtd_pkg::OutWaiting;
        end else begin
          ex_pend = m;
          ex_pend_tag = c.tag;
          if (!is_blocked(m)) begin
            ex_m = m;
            ex_active = 1'b1;
            a.outcome = dtd_pkg::OutGranted;
            a.tag = c.tag;
          end else begin
            ex_waiting = 1'b1;
            a.outcome = dtd_pkg::OutWaiting;
          end
        end
      end
      default: begin
        if (ex_active) begin
          ex_m = '0;
          ex_active = 1'b0;
        end
      end
    endcase
    a.qempty = (q_cnt == 0);
    a.idle = (wk_busy == 0) && !ex_waiting && !ex_active;
    return a;
  endfunction

  // Sparse masks keep hazards frequent but not universal.
  function automatic logic [31:0] rand_mask();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom();
      default: return 32'd1 << $urandom_range(0, 7);
    endcase
  endfunction

  function automatic cmd_item_t rand_cmd();
    cmd_item_t c;
    int r;
    r = $urandom_range(0, 99);
    c.cmd = (r < 45) ? dtd_pkg::CmdPush : (r < 85) ? dtd_pkg::CmdRequest :
            (r < 93) ? dtd_pkg::CmdExclReq : dtd_pkg::CmdExclDone;
    c.wid = 3'($urandom_range(0, 7));
    c.tag = 16'($urandom());
    c.rd = rand_mask();
    c.wr = rand_mask();
    c.qry = ($urandom_range(0, 3) == 0) ? $urandom() : (32'hF >> $urandom_range(0, 4));
    return c;
  endfunction

  function automatic cmd_item_t mk(logic [1:0] cmd, logic [2:0] wid, logic [15:0] tag,
                                   logic [31:0] rd, logic [31:0] wr, logic [31:0] qry);
    cmd_item_t c;
    c.cmd = cmd; c.wid = wid; c.tag = tag; c.rd = rd; c.wr = wr; c.qry = qry;
    return c;
  endfunction

  // Driver: offers items at the falling edge, holds them until accepted.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_accepted) begin
        if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cmd_item_t c;
          c = pending_cmds.pop_front();
          in_cmd <= c.cmd; in_worker_id <= c.wid; in_task_tag <= c.tag;
          in_read_mask <= c.rd; in_write_mask <= c.wr; in_query_mask <= c.qry;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= hold_off ? 1'b0 : ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: predicts on input acceptance and checks on output acceptance.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    in_accepted <= 1'b0;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        in_accepted <= 1'b1;
        expected_answers = {expected_answers,
                            schedule_step({in_cmd, in_worker_id, in_task_tag,
                                           in_read_mask, in_write_mask, in_query_mask})};
      end
      if (out_valid && out_ready) begin
        answer_t got, exp_a;
        got = {out_outcome, out_out_tag, out_out_worker, out_queue_empty, out_all_idle};
        checked++;
        if (expected_answers.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result transaction %h", got);
        end else begin
          exp_a = expected_answers.pop_front();
          if (got.outcome == dtd_pkg::OutDispatched) n_disp++;
          if (got.outcome == dtd_pkg::OutGranted) n_grant++;
          if (got.outcome == dtd_pkg::OutFull) n_full++;
          if (got !== exp_a) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch: outcome %0d/%0d tag %h/%h worker %0d/%0d ",
                        "empty %b/%b idle %b/%b"},
                       exp_a.outcome, got.outcome, exp_a.tag, got.tag, exp_a.worker,
                       got.worker, exp_a.qempty, got.qempty, exp_a.idle, got.idle);
          end
        end
      end
    end
    if (cycle > 400000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic drain();
    while (pending_cmds.size() > 0 || in_valid || expected_answers.size() > 0)
      @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic add_cmd(cmd_item_t c);
    pending_cmds = {pending_cmds, c};
  endtask

  task automatic fill_random(int n);
    for (int i = 0; i < n; i++) add_cmd(rand_cmd());
  endtask

  initial begin
    q_cnt = 0;
    wk_busy = '0;
    ex_m = '0; ex_pend = '0; ex_pend_tag = '0;
    ex_active = 1'b0; ex_waiting = 1'b0;
    for (int k = 0; k < dtd_pkg::NumWorkers; k++) wk_m[k] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, full queue, exclusive waiting and grants.
    add_cmd(mk(dtd_pkg::CmdRequest, 3'd0, 16'd0, '0, '0, '0));
    add_cmd(mk(dtd_pkg::CmdExclDone, 3'd7, 16'hFFFF, '1, '1, '1));
    add_cmd(mk(dtd_pkg::CmdPush, 3'd0, 16'hFFFF, '1, '1, '1));
    add_cmd(mk(dtd_pkg::CmdPush, 3'd7, 16'h0000, '0, '0, '0));
    for (int i = 0; i < 15; i++)
      add_cmd(mk(dtd_pkg::CmdPush, 3'd0, 16'(16'h100 + i), 32'd1 << i, 32'd1 << i,
                 32'h1));
    add_cmd(mk(dtd_pkg::CmdRequest, 3'd7, 16'd0, '0, '0, '0));
    add_cmd(mk(dtd_pkg::CmdExclReq, 3'd3, 16'hABCD, '1, '1, 32'h1));
    add_cmd(mk(dtd_pkg::CmdExclReq, 3'd3, 16'h1234, '0, '0, '0));
    add_cmd(mk(dtd_pkg::CmdRequest, 3'd7, 16'd0, '0, '0, '0));
    add_cmd(mk(dtd_pkg::CmdExclDone, 3'd0, 16'd0, '0, '0, '0));
    add_cmd(mk(dtd_pkg::CmdRequest, 3'd1, 16'd0, '0, '0, '0));
    drain();

    send_idle_pct = 0; recv_stall_pct = 0;   fill_random(400); drain();
    send_idle_pct = 77; recv_stall_pct = 0;  fill_random(300); drain();
    send_idle_pct = 0; recv_stall_pct = 77;  fill_random(300); drain();
    send_idle_pct = 17; recv_stall_pct = 17; fill_random(350);
    @(negedge clk);
    hold_go = 1'b1;
    drain();
    send_idle_pct = 0; recv_stall_pct = 0;   fill_random(375); drain();

    $display("Ran %0d result transactions: %0d dispatched, %0d exclusive grants, %0d drops.",
             checked, n_disp, n_grant, n_full);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
